/* sv/assert_macros.svh */
// Assertion macros used by the decoder back end
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, cond, res) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (res)) \
        else $error("assertion failed");
`else
`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_NEXT(label, clk, rst_n, cond, res)
`endif
`endif

/* sv/fcd_pkg.sv */
// Package: types and constants for the FLIC chunk decoder
package fcd_pkg;
    localparam int COORD_BITS = 16;
    localparam logic [COORD_BITS-1:0] COORD_MAX = {COORD_BITS{1'b1}};
    localparam int PAL_ENTRIES = 256;
    localparam int QDEPTH = 2;

    localparam logic [2:0] K_MAP256 = 3'd0;
    localparam logic [2:0] K_MAP64  = 3'd1;
    localparam logic [2:0] K_RUN    = 3'd2;
    localparam logic [2:0] K_FLI    = 3'd3;
    localparam logic [2:0] K_FLC    = 3'd4;

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;

    typedef struct packed {
        logic [2:0] chunk_kind;
        logic       chunk_start;
        logic [7:0] data_byte;
    } in_item_t;

    typedef struct packed {
        logic [15:0] span_x;
        logic [15:0] span_y;
        logic [8:0]  pixel_count;
        logic [23:0] color_even;
        logic [23:0] color_odd;
    } out_item_t;

    // back-end command: palette write or span with two palette indexes
    typedef struct packed {
        logic        pal_wr;
        logic [7:0]  pal_idx;
        logic [23:0] pal_rgb;
        logic [15:0] x;
        logic [15:0] y;
        logic [8:0]  n;
        logic [7:0]  idx_even;
        logic [7:0]  idx_odd;
    } cmd_t;

    // divide by 63 through a reciprocal multiply, exact for numerators below 16384
    function automatic logic [7:0] scale6(input logic [7:0] c);
        logic [15:0] p;
        logic [31:0] m;
        begin
            p = 16'(c) * 16'd255 + 16'd31;
            m = 32'(p) * 32'd16645;
            if (c >= 8'd63) scale6 = 8'd255;
            else scale6 = m[27:20];
        end
    endfunction

    function automatic logic [15:0] cadd(input logic [15:0] a, input logic [16:0] b);
        logic [17:0] s;
        begin
            s = 18'(a) + 18'(b);
            cadd = (s > 18'(COORD_MAX)) ? COORD_MAX : s[15:0];
        end
    endfunction
endpackage

/* sv/fcd_front.sv */
// Front end: byte parser that turns chunk bytes into palette writes and spans
module fcd_front import fcd_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_ok,
    input  in_item_t    in_item,
    input  logic [15:0] width,
    input  logic [15:0] height,
    output logic        cmd_valid,
    output cmd_t        cmd
);
    typedef enum logic [11:0] {
        PH_IDLE    = 12'b000000000001,
        PH_HDR0    = 12'b000000000010,
        PH_HDR1    = 12'b000000000100,
        PH_HDR2    = 12'b000000001000,
        PH_HDR3    = 12'b000000010000,
        PH_LINE    = 12'b000000100000,
        PH_LINE_HI = 12'b000001000000,
        PH_SKIP    = 12'b000010000000,
        PH_CODE    = 12'b000100000000,
        PH_LIT     = 12'b001000000000,
        PH_RUN1    = 12'b010000000000,
        PH_RUN2    = 12'b100000000000
    } phase_t;

    phase_t phase_reg, phase_next, ph;
    logic [2:0]  kind_reg, kind_next, k;
    logic [15:0] cx_reg, cx_next, cy_reg, cy_next;
    logic [15:0] lines_reg, lines_next, pk_reg, pk_next;
    logic [8:0]  run_reg, run_next;
    logic [7:0]  wlo_reg, wlo_next, fci_reg, fci_next;
    logic [15:0] pc_reg, pc_next;
    logic [9:0]  cb_reg, cb_next;
    logic [1:0]  slot_reg, slot_next;

    always_comb
    begin
        logic [7:0]  b, v;
        logic [15:0] w, cx, cy, lines, pk, pc, col;
        logic [8:0]  run;
        logic [7:0]  wlo, fci;
        logic [9:0]  cb;
        logic [1:0]  slot;
        logic        map, start, dle, rpe;
        logic [16:0] psum;
        b = in_item.data_byte;
        start = in_item.chunk_start;
        k = start ? in_item.chunk_kind : kind_reg;
        cx = start ? 16'd0 : cx_reg;
        cy = start ? 16'd0 : cy_reg;
        lines = start ? 16'd0 : lines_reg;
        pk = start ? 16'd0 : pk_reg;
        run = start ? 9'd0 : run_reg;
        wlo = start ? 8'd0 : wlo_reg;
        fci = start ? 8'd0 : fci_reg;
        pc = start ? 16'd0 : pc_reg;
        cb = start ? 10'd0 : cb_reg;
        slot = start ? 2'd0 : slot_reg;
        if (start)
        begin
            if (k == K_RUN) ph = PH_LINE;
            else if (k <= K_FLC) ph = PH_HDR0;
            else ph = PH_IDLE;
        end
        else ph = phase_reg;
        map = (k == K_MAP256) || (k == K_MAP64);
        w = {b, wlo};
        phase_next = ph;
        cmd_valid = 1'b0;
        cmd = '0;
        dle = 1'b0;
        rpe = 1'b0;
        psum = '0;
        v = (k == K_MAP64) ? scale6(b) : b;
        col = (width != 16'd0) ? width - 16'd1 : 16'd0;
        unique case (ph)
            PH_HDR0:
            begin
                wlo = b;
                phase_next = PH_HDR1;
            end
            PH_HDR1:
            begin
                if (map)
                begin
                    pk = w;
                    phase_next = (w != 16'd0) ? PH_SKIP : PH_IDLE;
                end
                else if (k == K_FLI)
                begin
                    cy = w;
                    phase_next = PH_HDR2;
                end
                else
                begin
                    lines = w;
                    phase_next = (w != 16'd0) ? PH_LINE : PH_IDLE;
                end
            end
            PH_HDR2:
            begin
                wlo = b;
                phase_next = PH_HDR3;
            end
            PH_HDR3:
            begin
                lines = w;
                phase_next = (w != 16'd0) ? PH_LINE : PH_IDLE;
            end
            PH_LINE:
            begin
                if (k == K_RUN) phase_next = PH_CODE;
                else if (k == K_FLI)
                begin
                    cx = 16'd0;
                    pk = 16'(b);
                    if (b == 8'd0)
                    begin
                        cy = cadd(cy, 17'd1);
                        cx = 16'd0;
                        lines = lines - 16'd1;
                        phase_next = (lines != 16'd0) ? PH_LINE : PH_IDLE;
                    end
                    else phase_next = PH_SKIP;
                end
                else
                begin
                    wlo = b;
                    phase_next = PH_LINE_HI;
                end
            end
            PH_LINE_HI:
            begin
                phase_next = PH_LINE;
                case (w[15:14])
                    2'b00:
                    begin
                        cx = 16'd0;
                        pk = w;
                        if (w == 16'd0)
                        begin
                            cy = cadd(cy, 17'd1);
                            lines = lines - 16'd1;
                            phase_next = (lines != 16'd0) ? PH_LINE : PH_IDLE;
                        end
                        else phase_next = PH_SKIP;
                    end
                    2'b11: cy = cadd(cy, 17'h10000 - 17'(w));
                    2'b10:
                    begin
                        cmd_valid = 1'b1;
                        cmd.x = col;
                        cmd.y = cy;
                        cmd.n = 9'd1;
                        cmd.idx_even = w[7:0];
                        cmd.idx_odd = w[7:0];
                    end
                    default: ;
                endcase
            end
            PH_SKIP:
            begin
                if (map)
                begin
                    psum = 17'(pc) + 17'(b);
                    pc = psum[16] ? 16'hFFFF : psum[15:0];
                end
                else cx = cadd(cx, 17'(b));
                phase_next = PH_CODE;
            end
            PH_CODE:
            begin
                if (map)
                begin
                    cb = (b != 8'd0) ? 10'(b) * 10'd3 : 10'd768;
                    slot = 2'd0;
                    phase_next = PH_LIT;
                end
                else if (k == K_RUN)
                begin
                    if (b[7])
                    begin
                        run = 9'd256 - 9'(b);
                        phase_next = PH_LIT;
                    end
                    else
                    begin
                        run = 9'(b);
                        phase_next = PH_RUN1;
                    end
                end
                else if (b[7])
                begin
                    run = 9'd256 - 9'(b);
                    phase_next = PH_RUN1;
                end
                else if (b == 8'd0) dle = 1'b1;
                else
                begin
                    run = (k == K_FLC) ? {b, 1'b0} : 9'(b);
                    phase_next = PH_LIT;
                end
            end
            PH_LIT:
            begin
                if (map)
                begin
                    // slot counts up as cb counts down: cb%3 == 0 first, 2 second, 1 third
                    if (slot == 2'd0) fci = v;
                    else if (slot == 2'd1) wlo = v;
                    else
                    begin
                        if (pc < 16'(PAL_ENTRIES))
                        begin
                            cmd_valid = 1'b1;
                            cmd.pal_wr = 1'b1;
                            cmd.pal_idx = pc[7:0];
                            cmd.pal_rgb = {fci, wlo, v};
                        end
                        if (pc != 16'hFFFF) pc = pc + 16'd1;
                    end
                    slot = (slot == 2'd2) ? 2'd0 : slot + 2'd1;
                    cb = cb - 10'd1;
                    if (cb == 10'd0)
                    begin
                        pk = pk - 16'd1;
                        phase_next = (pk != 16'd0) ? PH_SKIP : PH_IDLE;
                    end
                end
                else
                begin
                    cmd_valid = 1'b1;
                    cmd.x = cx;
                    cmd.y = cy;
                    cmd.n = 9'd1;
                    cmd.idx_even = b;
                    cmd.idx_odd = b;
                    cx = cadd(cx, 17'd1);
                    run = run - 9'd1;
                    if (run == 9'd0) rpe = 1'b1;
                end
            end
            PH_RUN1:
            begin
                if (k == K_FLC)
                begin
                    fci = b;
                    phase_next = PH_RUN2;
                end
                else
                begin
                    if (run != 9'd0)
                    begin
                        cmd_valid = 1'b1;
                        cmd.x = cx;
                        cmd.y = cy;
                        cmd.n = run;
                        cmd.idx_even = b;
                        cmd.idx_odd = b;
                    end
                    cx = cadd(cx, 17'(run));
                    rpe = 1'b1;
                end
            end
            PH_RUN2:
            begin
                cmd_valid = 1'b1;
                cmd.x = cx;
                cmd.y = cy;
                cmd.n = {run[7:0], 1'b0};
                cmd.idx_even = fci;
                cmd.idx_odd = b;
                cx = cadd(cx, {7'd0, run, 1'b0});
                dle = 1'b1;
            end
            default: phase_next = PH_IDLE;
        endcase
        if (rpe)
        begin
            if (k == K_RUN)
            begin
                if (cx >= width)
                begin
                    cx = 16'd0;
                    cy = cadd(cy, 17'd1);
                    phase_next = (cy >= height) ? PH_IDLE : PH_LINE;
                end
                else phase_next = PH_CODE;
            end
            else dle = 1'b1;
        end
        if (dle)
        begin
            pk = pk - 16'd1;
            if (pk == 16'd0)
            begin
                cy = cadd(cy, 17'd1);
                cx = 16'd0;
                lines = lines - 16'd1;
                phase_next = (lines != 16'd0) ? PH_LINE : PH_IDLE;
            end
            else phase_next = PH_SKIP;
        end
        if (!in_ok) cmd_valid = 1'b0;
        kind_next = k;
        cx_next = cx;
        cy_next = cy;
        lines_next = lines;
        pk_next = pk;
        run_next = run;
        wlo_next = wlo;
        fci_next = fci;
        pc_next = pc;
        cb_next = cb;
        slot_next = slot;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            kind_reg <= 3'd0;
            cx_reg <= '0;
            cy_reg <= '0;
            lines_reg <= '0;
            pk_reg <= '0;
            run_reg <= '0;
            wlo_reg <= '0;
            fci_reg <= '0;
            pc_reg <= '0;
            cb_reg <= '0;
            slot_reg <= '0;
        end
        else if (in_ok)
        begin
            phase_reg <= phase_next;
            kind_reg <= kind_next;
            cx_reg <= cx_next;
            cy_reg <= cy_next;
            lines_reg <= lines_next;
            pk_reg <= pk_next;
            run_reg <= run_next;
            wlo_reg <= wlo_next;
            fci_reg <= fci_next;
            pc_reg <= pc_next;
            cb_reg <= cb_next;
            slot_reg <= slot_next;
        end
    end
endmodule

/* sv/fcd_queue.sv */
// Short command queue between parser and palette back end
module fcd_queue import fcd_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic wr,
    input  cmd_t wdata,
    input  logic rd,
    output logic empty,
    output logic full,
    output cmd_t rdata
);
    cmd_t mem_reg [QDEPTH];
    logic [$clog2(QDEPTH)-1:0] wp_reg, rp_reg;
    logic [$clog2(QDEPTH):0] cnt_reg;

    assign empty = (cnt_reg == '0);
    assign full = (cnt_reg == ($clog2(QDEPTH)+1)'(QDEPTH));
    assign rdata = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (wr) mem_reg[wp_reg] <= wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr) wp_reg <= wp_reg + 1'b1;
            if (rd) rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + ($clog2(QDEPTH)+1)'(wr) - ($clog2(QDEPTH)+1)'(rd);
        end
    end
endmodule

/* sv/fcd_back.sv */
// Back end: palette store, colour lookup and output register
module fcd_back import fcd_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      q_empty,
    input  cmd_t      q_data,
    output logic      q_rd,
    output logic      valid,
    input  logic      stall,
    output out_item_t out_item
);
`include "assert_macros.svh"
    // palette in flops with per-entry valid bits (reset reads as zero)
    logic [23:0] pal_reg [PAL_ENTRIES];
    logic [PAL_ENTRIES-1:0] pv_reg;
    logic valid_reg;
    out_item_t out_reg;
    logic out_free;

    assign out_free = !valid_reg || !stall;
    assign q_rd = !q_empty && (q_data.pal_wr || out_free);
    assign valid = valid_reg;
    assign out_item = out_reg;

    always_ff @(posedge clk)
    begin
        if (q_rd && q_data.pal_wr) pal_reg[q_data.pal_idx] <= q_data.pal_rgb;
        if (q_rd && !q_data.pal_wr)
        begin
            out_reg.span_x <= q_data.x;
            out_reg.span_y <= q_data.y;
            out_reg.pixel_count <= q_data.n;
            out_reg.color_even <= pv_reg[q_data.idx_even] ? pal_reg[q_data.idx_even] : 24'd0;
            out_reg.color_odd <= pv_reg[q_data.idx_odd] ? pal_reg[q_data.idx_odd] : 24'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pv_reg <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (q_rd && q_data.pal_wr) pv_reg[q_data.pal_idx] <= 1'b1;
            if (q_rd && !q_data.pal_wr) valid_reg <= 1'b1;
            else if (!stall) valid_reg <= 1'b0;
        end
    end

    `ASSERT_NEXT(a_hold, clk, rst_n, valid_reg && stall, valid_reg && $stable(out_reg))
    `ASSERT_NEXT(a_pal, clk, rst_n, q_rd && q_data.pal_wr, pv_reg[$past(q_data.pal_idx)])
    `ASSERT_CLK(a_cnt, clk, rst_n, q_rd |-> !q_empty)
endmodule

/* sv/flic_chunk_decoder.sv */
// FLIC frame chunk decoder: one byte per cycle, spans via palette back end
// Path: a span is written into the command queue, then read into the output register.
// Throughput: one byte per cycle; input stalls only when the two-entry
// command queue is full behind a stalled output.
// Reset: asynchronous, clears parser, queue, output and palette valid bits
// (palette reads as zero until written); registers return to 320 x 200.
module flic_chunk_decoder import fcd_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  in_item_t    in_item,
    output logic        out_valid,
    input  logic        out_stall,
    output out_item_t   out_item,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    logic [15:0] width_reg, height_reg;
    logic in_ok, cmd_valid, q_empty, q_full, q_rd;
    cmd_t cmd, q_data;

    assign pready = 1'b1;
    assign in_stall = q_full;
    assign in_ok = in_valid && !q_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg <= 16'd320;
            height_reg <= 16'd200;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (paddr[2])
                REG_WIDTH[0]:  width_reg <= pwdata[15:0];
                REG_HEIGHT[0]: height_reg <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_WIDTH[0]: prdata = {16'd0, width_reg};
            default:      prdata = {16'd0, height_reg};
        endcase
    end

    fcd_front u_front (
        .clk(clk), .rst_n(rst_n), .in_ok(in_ok), .in_item(in_item),
        .width(width_reg), .height(height_reg), .cmd_valid(cmd_valid), .cmd(cmd)
    );

    fcd_queue u_queue (
        .clk(clk), .rst_n(rst_n), .wr(cmd_valid), .wdata(cmd), .rd(q_rd),
        .empty(q_empty), .full(q_full), .rdata(q_data)
    );

    fcd_back u_back (
        .clk(clk), .rst_n(rst_n), .q_empty(q_empty), .q_data(q_data), .q_rd(q_rd),
        .valid(out_valid), .stall(out_stall), .out_item(out_item)
    );
endmodule

/* bench/tb.sv */
// Testbench for flic_chunk_decoder: directed table, random chunk streams, span predictor
module tb;
    import fcd_pkg::*;

    typedef enum int {
        P_IDLE, P_HDR0, P_HDR1, P_HDR2, P_HDR3, P_LINE, P_LINE_HI,
        P_SKIP, P_CODE, P_LIT, P_RUN1, P_RUN2
    } phase_e;

    typedef struct {
        in_item_t  it;
        bit        chk;
        out_item_t want;
    } row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    in_item_t    in_item;
    logic        out_valid;
    logic        out_stall;
    out_item_t   out_item;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    flic_chunk_decoder DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
        .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    // decoder image held by the predictor
    int unsigned scr_w, scr_h;
    phase_e      ph;
    logic [2:0]  akind;
    int unsigned cx, cy, lines_left, pkts, run_len, lo_byte, idx_first, pal_pos, comp_left;
    logic [23:0] pal [256];

    out_item_t   spans[$];
    row_t        stim[$];
    int          errors;
    int          hold_go;

    // after reset, 320 x 200: map256 entry 0, map64 entry 1, run spans, FLC last pixel
    row_t dir_tab[] = '{
        '{{K_MAP256, 1'b1, 8'h01}, 1'b0, '0},
        '{{K_MAP256, 1'b0, 8'h00}, 1'b0, '0},
        '{{K_MAP256, 1'b0, 8'h00}, 1'b0, '0},
        '{{K_MAP256, 1'b0, 8'h01}, 1'b0, '0},
        '{{K_MAP256, 1'b0, 8'hFF}, 1'b0, '0},
        '{{K_MAP256, 1'b0, 8'h00}, 1'b0, '0},
        '{{K_MAP256, 1'b0, 8'h80}, 1'b0, '0},
        '{{K_MAP64,  1'b1, 8'h01}, 1'b0, '0},
        '{{K_MAP64,  1'b0, 8'h00}, 1'b0, '0},
        '{{K_MAP64,  1'b0, 8'h01}, 1'b0, '0},
        '{{K_MAP64,  1'b0, 8'h01}, 1'b0, '0},
        '{{K_MAP64,  1'b0, 8'h3F}, 1'b0, '0},
        '{{K_MAP64,  1'b0, 8'h00}, 1'b0, '0},
        '{{K_MAP64,  1'b0, 8'h20}, 1'b0, '0},
        '{{K_RUN,    1'b1, 8'h00}, 1'b0, '0},
        '{{K_RUN,    1'b0, 8'h02}, 1'b0, '0},
        '{{K_RUN,    1'b0, 8'h00}, 1'b1, {16'd0, 16'd0, 9'd2, 24'hFF0080, 24'hFF0080}},
        '{{K_RUN,    1'b0, 8'hFF}, 1'b0, '0},
        '{{K_RUN,    1'b0, 8'h01}, 1'b1, {16'd2, 16'd0, 9'd1, 24'hFF0082, 24'hFF0082}},
        '{{K_FLC,    1'b1, 8'h01}, 1'b0, '0},
        '{{K_FLC,    1'b0, 8'h00}, 1'b0, '0},
        '{{K_FLC,    1'b0, 8'h01}, 1'b0, '0},
        '{{K_FLC,    1'b0, 8'h80}, 1'b1, {16'd319, 16'd0, 9'd1, 24'hFF0082, 24'hFF0082}},
        '{{3'd7,     1'b1, 8'h00}, 1'b0, '0},
        '{{K_RUN,    1'b0, 8'h05}, 1'b0, '0}
    };

    function automatic int unsigned sat(int unsigned a, int unsigned b);
        return (a + b > 32'hFFFF) ? 32'hFFFF : a + b;
    endfunction

    function automatic out_item_t span(int unsigned x, int unsigned y, int unsigned n,
                                       logic [23:0] ce, logic [23:0] co);
        return {16'(x), 16'(y), 9'(n), ce, co};
    endfunction

    function automatic void line_done();
        cy = sat(cy, 1);
        cx = 0;
        lines_left = (lines_left - 1) & 32'hFFFF;
        ph = lines_left ? P_LINE : P_IDLE;
    endfunction

    function automatic void delta_done();
        pkts = (pkts - 1) & 32'hFFFF;
        if (pkts == 0)
            line_done();
        else
            ph = P_SKIP;
    endfunction

    function automatic void packet_done();
        if (akind == K_RUN)
        begin
            if (cx >= scr_w)
            begin
                cx = 0;
                cy = sat(cy, 1);
                ph = (cy >= scr_h) ? P_IDLE : P_LINE;
            end
            else
                ph = P_CODE;
        end
        else
            delta_done();
    endfunction

    // advances the decoder image by one byte; returns 1 when a span results
    function automatic bit decode_byte(input in_item_t it, output out_item_t o);
        int unsigned b, w, v, slot, col;
        bit is_map, hit;
        b = it.data_byte;
        w = (b << 8) | lo_byte;
        is_map = (akind == K_MAP256 || akind == K_MAP64);
        hit = 0;
        o = '0;
        if (it.chunk_start)
        begin
            akind = it.chunk_kind;
            is_map = (akind == K_MAP256 || akind == K_MAP64);
            cx = 0; cy = 0; lines_left = 0; pkts = 0; run_len = 0;
            lo_byte = 0; idx_first = 0; pal_pos = 0; comp_left = 0;
            if (akind == K_RUN)
                ph = P_LINE;
            else if (akind <= K_FLC)
                ph = P_HDR0;
            else
                ph = P_IDLE;
            w = b << 8;
        end
        case (ph)
            P_HDR0:
            begin
                lo_byte = b;
                ph = P_HDR1;
            end
            P_HDR1:
            begin
                if (is_map)
                begin
                    pkts = w;
                    ph = w ? P_SKIP : P_IDLE;
                end
                else if (akind == K_FLI)
                begin
                    cy = w;
                    ph = P_HDR2;
                end
                else
                begin
                    lines_left = w;
                    ph = w ? P_LINE : P_IDLE;
                end
            end
            P_HDR2:
            begin
                lo_byte = b;
                ph = P_HDR3;
            end
            P_HDR3:
            begin
                lines_left = w;
                ph = w ? P_LINE : P_IDLE;
            end
            P_LINE:
            begin
                if (akind == K_RUN)
                    ph = P_CODE;
                else if (akind == K_FLI)
                begin
                    cx = 0;
                    pkts = b;
                    if (b == 0)
                        line_done();
                    else
                        ph = P_SKIP;
                end
                else
                begin
                    lo_byte = b;
                    ph = P_LINE_HI;
                end
            end
            P_LINE_HI:
            begin
                ph = P_LINE;
                case (w >> 14)
                    0:
                    begin
                        cx = 0;
                        pkts = w;
                        if (w == 0)
                            line_done();
                        else
                            ph = P_SKIP;
                    end
                    3: cy = sat(cy, 32'h10000 - w);
                    2:
                    begin
                        col = scr_w ? scr_w - 1 : 0;
                        o = span(col, cy, 1, pal[w & 8'hFF], pal[w & 8'hFF]);
                        hit = 1;
                    end
                    default: ;
                endcase
            end
            P_SKIP:
            begin
                if (is_map)
                    pal_pos = sat(pal_pos, b);
                else
                    cx = sat(cx, b);
                ph = P_CODE;
            end
            P_CODE:
            begin
                if (is_map)
                begin
                    comp_left = 3 * (b ? b : 256);
                    ph = P_LIT;
                end
                else if (akind == K_RUN)
                begin
                    if (b >= 128)
                    begin
                        run_len = 256 - b;
                        ph = P_LIT;
                    end
                    else
                    begin
                        run_len = b;
                        ph = P_RUN1;
                    end
                end
                else if (b >= 128)
                begin
                    run_len = 256 - b;
                    ph = P_RUN1;
                end
                else if (b == 0)
                    delta_done();
                else
                begin
                    run_len = (akind == K_FLC) ? 2 * b : b;
                    ph = P_LIT;
                end
            end
            P_LIT:
            begin
                if (is_map)
                begin
                    if (akind == K_MAP64)
                        v = (b >= 63) ? 255 : (b * 255 + 31) / 63;
                    else
                        v = b;
                    slot = comp_left % 3;
                    if (slot == 0)
                        idx_first = v;
                    else if (slot == 2)
                        lo_byte = v;
                    else
                    begin
                        if (pal_pos < 256)
                            pal[pal_pos] = {8'(idx_first), 8'(lo_byte), 8'(v)};
                        if (pal_pos < 32'hFFFF)
                            pal_pos++;
                    end
                    comp_left--;
                    if (comp_left == 0)
                    begin
                        pkts = (pkts - 1) & 32'hFFFF;
                        ph = pkts ? P_SKIP : P_IDLE;
                    end
                end
                else
                begin
                    o = span(cx, cy, 1, pal[b], pal[b]);
                    hit = 1;
                    cx = sat(cx, 1);
                    run_len = (run_len - 1) & 9'h1FF;
                    if (run_len == 0)
                        packet_done();
                end
            end
            P_RUN1:
            begin
                if (akind == K_FLC)
                begin
                    idx_first = b;
                    ph = P_RUN2;
                end
                else
                begin
                    if (run_len)
                    begin
                        o = span(cx, cy, run_len, pal[b], pal[b]);
                        hit = 1;
                    end
                    cx = sat(cx, run_len);
                    packet_done();
                end
            end
            P_RUN2:
            begin
                o = span(cx, cy, 2 * run_len, pal[idx_first], pal[b]);
                hit = 1;
                cx = sat(cx, 2 * run_len);
                delta_done();
            end
            default: ph = P_IDLE;
        endcase
        return hit;
    endfunction

    function automatic void put(logic [2:0] kind, bit start, int unsigned b);
        row_t r;
        r.it = {start ? kind : 3'($urandom_range(0, 7)), start, 8'(b)};
        r.chk = 0;
        r.want = '0;
        stim.push_back(r);
    endfunction

    // one random chunk, mostly well formed, sometimes cut short or followed by stray bytes
    function automatic void gen_chunk();
        int unsigned kind, n, lines, np, sel, base;
        base = stim.size();
        sel = $urandom_range(0, 19);
        kind = (sel < 4) ? K_MAP256 : (sel < 6) ? K_MAP64 : (sel < 10) ? K_RUN :
               (sel < 14) ? K_FLI : (sel < 18) ? K_FLC : $urandom_range(5, 7);
        if (kind == K_MAP256 || kind == K_MAP64)
        begin
            np = $urandom_range(1, 3);
            put(kind, 1, np);
            put(kind, 0, 0);
            repeat (np)
            begin
                put(kind, 0, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) :
                    $urandom_range(0, 8));
                n = ($urandom_range(0, 40) == 0) ? 0 : $urandom_range(1, 6);
                put(kind, 0, n);
                repeat (3 * (n ? n : 256))
                    put(kind, 0, $urandom_range(0, 255));
            end
        end
        else if (kind == K_RUN)
        begin
            put(kind, 1, $urandom_range(0, 255));
            repeat ($urandom_range(10, 60))
                put(kind, 0, ($urandom_range(0, 2) == 0) ? $urandom_range(0, 255) :
                    ($urandom_range(0, 1) ? $urandom_range(0, 6) : 256 - $urandom_range(1, 6)));
        end
        else if (kind == K_FLI || kind == K_FLC)
        begin
            lines = $urandom_range(1, 3);
            if (kind == K_FLI)
            begin
                n = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 16'hFFFF) :
                    $urandom_range(0, 20);
                put(kind, 1, n & 8'hFF);
                put(kind, 0, n >> 8);
                put(kind, 0, lines);
            end
            else
                put(kind, 1, lines);
            put(kind, 0, 0);
            while (lines > 0)
            begin
                sel = $urandom_range(0, 9);
                if (kind == K_FLC && sel >= 6)
                begin
                    n = (sel == 6) ? (16'hC000 | $urandom_range(0, 16'h3FFF)) :
                        (sel == 7) ? (16'h8000 | $urandom_range(0, 16'h3FFF)) :
                        (16'h4000 | $urandom_range(0, 16'h3FFF));
                    put(kind, 0, n & 8'hFF);
                    put(kind, 0, n >> 8);
                    continue;
                end
                np = $urandom_range(0, 3);
                put(kind, 0, np);
                if (kind == K_FLC)
                    put(kind, 0, 0);
                lines--;
                repeat (np)
                begin
                    put(kind, 0, $urandom_range(0, 255));
                    sel = $urandom_range(0, 4);
                    if (sel == 0)
                        put(kind, 0, 0);
                    else if (sel < 3)
                    begin
                        n = $urandom_range(1, 5);
                        put(kind, 0, n);
                        repeat ((kind == K_FLC) ? 2 * n : n)
                            put(kind, 0, $urandom_range(0, 255));
                    end
                    else
                    begin
                        put(kind, 0, 256 - (($urandom_range(0, 9) == 0) ? 128 :
                            $urandom_range(1, 60)));
                        repeat ((kind == K_FLC) ? 2 : 1)
                            put(kind, 0, $urandom_range(0, 255));
                    end
                end
            end
        end
        else
            repeat ($urandom_range(1, 6))
                put(kind, stim.size() == base, $urandom_range(0, 255));
        if ($urandom_range(0, 9) == 0 && stim.size() > base + 2)
            repeat ($urandom_range(1, stim.size() - base - 1))
                void'(stim.pop_back());
        repeat (($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0)
            put(3'd0, 0, $urandom_range(0, 255));
    endfunction

    task automatic send_stim();
        int pos, burst, gap;
        out_item_t o;
        pos = 0;
        burst = $urandom_range(1, 40);
        gap = 0;
        while (pos < stim.size() || in_valid)
        begin
            @(posedge clk);
            if (in_valid && !in_stall)
            begin
                if (decode_byte(stim[pos].it, o))
                    spans.push_back(o);
                if (stim[pos].chk)
                begin
                    if (spans.size() == 0)
                    begin
                        $error("directed row %0d: span exp %h got none", pos,
                               stim[pos].want);
                        errors++;
                    end
                    else if (spans[$] !== stim[pos].want)
                    begin
                        $error("directed row %0d: span exp %h got %h", pos,
                               stim[pos].want, spans[$]);
                        errors++;
                    end
                end
                pos++;
            end
            else if (in_valid)
                continue;
            if (gap > 0)
            begin
                gap--;
                in_valid <= 1'b0;
            end
            else if (pos < stim.size())
            begin
                in_valid <= 1'b1;
                in_item <= stim[pos].it;
                burst--;
                if (burst <= 0)
                begin
                    burst = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 120 : 20);
                    gap = $urandom_range(0, 2) ? $urandom_range(1, 6) : 0;
                end
            end
            else
                in_valid <= 1'b0;
        end
        stim.delete();
    endtask

    task automatic drain();
        while (spans.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic reg_write(logic [1:0] idx, int unsigned v);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 1'b0} << 1;
        pwdata <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        if (idx == REG_WIDTH)
            scr_w = v;
        else
            scr_h = v;
    endtask

    // result checker and stall pattern
    initial
    begin
        int hold_cnt, pct, cyc;
        out_item_t e;
        hold_cnt = 0;
        pct = 0;
        cyc = 0;
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
            begin
                if (spans.size() == 0)
                begin
                    $error("span with none expected: x=%0d y=%0d", out_item.span_x,
                           out_item.span_y);
                    errors++;
                end
                else
                begin
                    e = spans.pop_front();
                    if (out_item.span_x !== e.span_x)
                    begin
                        $error("span_x exp %0d got %0d", e.span_x, out_item.span_x);
                        errors++;
                    end
                    if (out_item.span_y !== e.span_y)
                    begin
                        $error("span_y exp %0d got %0d", e.span_y, out_item.span_y);
                        errors++;
                    end
                    if (out_item.pixel_count !== e.pixel_count)
                    begin
                        $error("pixel_count exp %0d got %0d", e.pixel_count,
                               out_item.pixel_count);
                        errors++;
                    end
                    if (out_item.color_even !== e.color_even)
                    begin
                        $error("color_even exp %h got %h", e.color_even, out_item.color_even);
                        errors++;
                    end
                    if (out_item.color_odd !== e.color_odd)
                    begin
                        $error("color_odd exp %h got %h", e.color_odd, out_item.color_odd);
                        errors++;
                    end
                end
            end
            if (hold_go)
            begin
                hold_go = 0;
                hold_cnt = 400;
            end
            if (cyc % 50 == 0)
                pct = $urandom_range(0, 3) * 30;
            cyc++;
            if (hold_cnt > 0)
            begin
                hold_cnt--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= ($urandom_range(0, 99) < pct);
        end
    end

    // watchdog on cycles without any transfer
    initial
    begin
        int quiet;
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel)
                quiet = 0;
            else
                quiet++;
            if (quiet >= 20000)
            begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        int unsigned cfg_w[7];
        int unsigned cfg_h[7];
        cfg_w = '{320, 16, 1, 0, 65535, 40, 7};
        cfg_h = '{200, 8, 1, 0, 65535, 3, 0};
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_item = '0;
        out_stall = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        errors = 0;
        hold_go = 0;
        scr_w = 320;
        scr_h = 200;
        ph = P_IDLE;
        akind = K_MAP256;
        cx = 0; cy = 0; lines_left = 0; pkts = 0; run_len = 0;
        lo_byte = 0; idx_first = 0; pal_pos = 0; comp_left = 0;
        foreach (pal[i])
            pal[i] = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        foreach (dir_tab[i])
            stim.push_back(dir_tab[i]);
        send_stim();

        for (int p = 0; p < 7; p++)
        begin
            drain();
            reg_write(REG_WIDTH, cfg_w[p]);
            reg_write(REG_HEIGHT, cfg_h[p]);
            while (stim.size() < 170)
                gen_chunk();
            if (p == 1)
                hold_go = 1;
            send_stim();
        end

        drain();
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
